// ===== rtl/core/b64e_pkg.sv =====
// Package: shared types, constants and the alphabet lookup for the base64 stream encoder.
`timescale 1ns / 1ps
package b64e_pkg;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    PH0 = 2'd0,
    PH1 = 2'd1,
    PH2 = 2'd2
  } phase_t;

  // One accepted byte turns into one to four characters.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;
    logic            last;
  } cmd_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] carry;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h2F;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/b64e_byte_if.sv =====
// Interface: byte channel into the encoder.
`timescale 1ns / 1ps
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

// ===== rtl/core/b64e_char_if.sv =====
// Interface: character channel out of the encoder.
`timescale 1ns / 1ps
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink (input valid, input out_char, input final_char, output ready);
endinterface

// ===== rtl/core/b64e_front.sv =====
// Front end: accepts bytes, tracks group phase and carry, builds character commands.
`timescale 1ns / 1ps
module b64e_front (
  input  logic                 clk,
  input  logic                 rst,
  b64e_byte_if.sink            byte_ch,
  input  logic                 q_full,
  output logic                 push,
  output b64e_pkg::cmd_t       cmd,
  output b64e_pkg::front_stat_t stat
);

  b64e_pkg::phase_t phase;
  b64e_pkg::phase_t phase_next;
  logic [3:0]       carry;
  logic [3:0]       carry_next;
  logic [7:0]       b;
  logic             last;

  assign b             = byte_ch.data_byte;
  assign last          = byte_ch.is_last;
  assign byte_ch.ready = !q_full;
  assign push          = byte_ch.valid && !q_full;
  assign stat.phase    = phase;
  assign stat.carry    = carry;

  // next state
  always_comb begin
    case (phase)
      b64e_pkg::PH1: begin
        phase_next = b64e_pkg::PH2;
        carry_next = b[3:0];
      end
      b64e_pkg::PH2: begin
        phase_next = b64e_pkg::PH0;
        carry_next = 4'd0;
      end
      default: begin
        phase_next = b64e_pkg::PH1;
        carry_next = {2'b00, b[1:0]};
      end
    endcase
    if (last) begin
      phase_next = b64e_pkg::PH0;
      carry_next = 4'd0;
    end
  end

  // command outputs
  always_comb begin
    cmd.chars  = {4{b64e_pkg::PAD_CHAR}};
    cmd.cnt_m1 = 2'd0;
    cmd.last   = last;
    case (phase)
      b64e_pkg::PH1: begin
        cmd.chars[0] = b64e_pkg::b64_char({carry[1:0], b[7:4]});
        cmd.chars[1] = b64e_pkg::b64_char({b[3:0], 2'b00});
        cmd.cnt_m1   = last ? 2'd2 : 2'd0;
      end
      b64e_pkg::PH2: begin
        cmd.chars[0] = b64e_pkg::b64_char({carry, b[7:6]});
        cmd.chars[1] = b64e_pkg::b64_char(b[5:0]);
        cmd.cnt_m1   = 2'd1;
      end
      default: begin
        cmd.chars[0] = b64e_pkg::b64_char(b[7:2]);
        cmd.chars[1] = b64e_pkg::b64_char({b[1:0], 4'b0000});
        cmd.cnt_m1   = last ? 2'd3 : 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= b64e_pkg::PH0;
      carry <= 4'd0;
    end else if (push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

// ===== rtl/core/b64e_queue.sv =====
// Short command queue between front end and character emitter.
`timescale 1ns / 1ps
module b64e_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64e_pkg::cmd_t     push_data,
  input  logic               pop,
  output b64e_pkg::cmd_t     pop_data,
  output b64e_pkg::q_stat_t  stat
);

  localparam logic [b64e_pkg::Q_AW-1:0] PTR_LAST = b64e_pkg::Q_AW'(b64e_pkg::Q_DEPTH - 1);
  localparam logic [b64e_pkg::Q_CW-1:0] CNT_FULL = b64e_pkg::Q_CW'(b64e_pkg::Q_DEPTH);

  b64e_pkg::cmd_t               entries [b64e_pkg::Q_DEPTH];
  logic [b64e_pkg::Q_AW-1:0]    wr_ptr;
  logic [b64e_pkg::Q_AW-1:0]    rd_ptr;
  logic [b64e_pkg::Q_CW-1:0]    count;
  logic                         do_push;
  logic                         do_pop;

  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back end: emits the characters of each command, one item per cycle while the output channel is ready.
`timescale 1ns / 1ps
module b64e_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  b64e_pkg::cmd_t   q_data,
  output logic             pop,
  b64e_char_if.source      char_ch
);

  b64e_pkg::cmd_t cur;
  logic           cur_valid;
  logic [1:0]     idx;
  logic           at_end;
  logic           take;

  assign at_end             = (idx == cur.cnt_m1);
  assign take               = char_ch.valid && char_ch.ready;
  assign pop                = !q_empty && (!cur_valid || (take && at_end));
  assign char_ch.valid      = cur_valid;
  assign char_ch.out_char   = cur.chars[idx];
  assign char_ch.final_char = cur.last && at_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (at_end) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/base64_stream_encoder.sv =====
// Base64 stream encoder: three bytes in, four characters out, '=' padding at message end.
// The first character of a byte is offered once its command has passed the queue and been loaded into the back end.
// Throughput: one character per cycle while the output channel is ready;
//   the one-character output channel sets that figure.
// Bytes keep being accepted while the 2-entry command queue has room.
// Reset (rst, synchronous) clears group phase, carry, queue and output state.
`timescale 1ns / 1ps
module base64_stream_encoder (
  input  logic         clk,
  input  logic         rst,
  b64e_byte_if.sink    byte_ch,
  b64e_char_if.source  char_ch
);

  logic                  push;
  logic                  pop;
  b64e_pkg::cmd_t        push_cmd;
  b64e_pkg::cmd_t        pop_cmd;
  b64e_pkg::q_stat_t     q_st;
  b64e_pkg::front_stat_t front_st;

  b64e_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_full  (q_st.full),
    .push    (push),
    .cmd     (push_cmd),
    .stat    (front_st)
  );

  b64e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .stat      (q_st)
  );

  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_st.empty),
    .q_data  (pop_cmd),
    .pop     (pop),
    .char_ch (char_ch)
  );

  assert property (@(posedge clk) disable iff (rst) !(q_st.full && q_st.empty))
    else $error("queue flagged both full and empty");

  assert property (@(posedge clk) disable iff (rst)
    (byte_ch.valid && byte_ch.ready && byte_ch.is_last)
    |=> (front_st.phase == b64e_pkg::PH0 && front_st.carry == 4'd0))
    else $error("group state not cleared after last byte");

  assert property (@(posedge clk) disable iff (rst)
    $rose(char_ch.valid) |-> $past(!q_st.empty))
    else $error("output went valid without a queued command");

endmodule
